// ----- src/assert_macros.svh -----
// Assertion helpers shared by the checker files.
// Both expect a signal named clk in the enclosing scope; WUF_ASSERT also uses rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define WUF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define WUF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/wuf_pkg.sv -----
package wuf_pkg;

  // Width of an element index on the channel
  localparam int ELEM_W = 10;

  // Operation codes
  localparam logic CMD_UNION = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Sequencer states
  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_WALK_A = 7'b0000100,
    S_WALK_B = 7'b0001000,
    S_LINK   = 7'b0010000,
    S_GROW   = 7'b0100000,
    S_DONE   = 7'b1000000
  } wuf_state_t;

endpackage

// ----- src/wuf_in_if.sv -----
interface wuf_in_if import wuf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [ELEM_W-1:0] first_elem;
  logic [ELEM_W-1:0] second_elem;

  modport source (output valid, cmd, first_elem, second_elem, input ready);
  modport sink   (input valid, cmd, first_elem, second_elem, output ready);
endinterface

// ----- src/wuf_out_if.sv -----
interface wuf_out_if ();
  logic valid;
  logic ready;
  logic same_set;

  modport source (output valid, same_set, input ready);
  modport sink   (input valid, same_set, output ready);
endinterface

// ----- src/wuf_ram.sv -----
module wuf_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 21
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/weighted_union_find.sv -----
// Weighted quick-union engine over NUM_ELEMENTS elements.
// in_ch carries one operation per item: cmd (union or connected query) and
// two element indices. out_ch returns one item per input: same_set is 1 when
// both elements had one root before the operation. An index of NUM_ELEMENTS
// or more leaves the tables alone and returns 0.
// Each element's parent link and set size share one word of a RAM with one
// read and one write port. A root walk follows one link per cycle; da and db,
// the link depths of the two elements, are at most log2(NUM_ELEMENTS) each.
// A query or a union of joined elements is posted after the two walks; a real
// union first writes the smaller root's link and then the larger root's size.
// The sequencer goes back to idle as the result is posted and only then takes
// the next item, so items are handled one at a time. An out-of-range item skips
// the walks and goes straight to the result.
// in_ch.ready is high only while the sequencer is idle.
// After reset a clearing pass over all NUM_ELEMENTS entries rewrites each to
// its own root with size one; in_ch.ready stays low until it ends.
// The result sits in an output register; a finished item waits there while
// out_ch.ready is low, and the next item is accepted meanwhile, but its own
// result is held back until the register frees up.
module weighted_union_find import wuf_pkg::*; #(
  parameter int NUM_ELEMENTS = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  wuf_in_if.sink    in_ch,
  wuf_out_if.source out_ch
);

  localparam int IDX_W = $clog2(NUM_ELEMENTS);
  localparam int SZ_W  = $clog2(NUM_ELEMENTS + 1);
  localparam int DW    = IDX_W + SZ_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ELEMENTS - 1);

  wuf_state_t state_r, state_nxt;
  logic [IDX_W-1:0] clr_r, clr_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_same_r, out_same_nxt;
  logic             cmd_r, cmd_nxt;
  logic             same_r, same_nxt;
  logic [IDX_W-1:0] b_r, b_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [IDX_W-1:0] ra_r, ra_nxt;
  logic [SZ_W-1:0]  sa_r, sa_nxt;
  logic [SZ_W-1:0]  sb_r, sb_nxt;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [DW-1:0]    mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  logic [DW-1:0]    mem_rdata;

  logic [IDX_W-1:0] rd_parent;
  logic [SZ_W-1:0]  rd_size;
  logic             out_free;
  logic             in_range;
  logic             a_big;
  logic [IDX_W-1:0] big_root;
  logic [IDX_W-1:0] small_root;
  logic [SZ_W-1:0]  small_size;

  // Parent link in the low bits, set size above it
  wuf_ram #(
    .DEPTH (NUM_ELEMENTS),
    .AW    (IDX_W),
    .DW    (DW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_parent = mem_rdata[IDX_W-1:0];
  assign rd_size   = mem_rdata[IDX_W +: SZ_W];

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_range = (32'(in_ch.first_elem) < NUM_ELEMENTS) &&
                    (32'(in_ch.second_elem) < NUM_ELEMENTS);

  // Tie goes under the first root; cur_r holds the second root here
  assign a_big      = (sa_r >= sb_r);
  assign big_root   = a_big ? ra_r : cur_r;
  assign small_root = a_big ? cur_r : ra_r;
  assign small_size = a_big ? sb_r : sa_r;

  assign in_ch.ready     = (state_r == S_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.same_set = out_same_r;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_same_nxt  = out_same_r;
    cmd_nxt       = cmd_r;
    same_nxt      = same_r;
    b_nxt         = b_r;
    cur_nxt       = cur_r;
    ra_nxt        = ra_r;
    sa_nxt        = sa_r;
    sb_nxt        = sb_r;
    mem_we        = 1'b0;
    mem_waddr     = clr_r;
    mem_wdata     = {SZ_W'(1), clr_r};
    mem_raddr     = cur_r;

    unique case (state_r)
      S_CLEAR: begin
        mem_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt = in_ch.cmd;
          b_nxt   = IDX_W'(in_ch.second_elem);
          if (in_range) begin
            cur_nxt   = IDX_W'(in_ch.first_elem);
            mem_raddr = IDX_W'(in_ch.first_elem);
            state_nxt = S_WALK_A;
          end else begin
            same_nxt  = 1'b0;
            state_nxt = S_DONE;
          end
        end
      end
      S_WALK_A: begin
        if (rd_parent == cur_r) begin
          ra_nxt    = cur_r;
          sa_nxt    = rd_size;
          cur_nxt   = b_r;
          mem_raddr = b_r;
          state_nxt = S_WALK_B;
        end else begin
          cur_nxt   = rd_parent;
          mem_raddr = rd_parent;
        end
      end
      S_WALK_B: begin
        if (rd_parent == cur_r) begin
          sb_nxt = rd_size;
          if (cur_r == ra_r) begin
            same_nxt  = 1'b1;
            state_nxt = S_DONE;
          end else begin
            same_nxt  = 1'b0;
            state_nxt = (cmd_r == CMD_UNION) ? S_LINK : S_DONE;
          end
        end else begin
          cur_nxt   = rd_parent;
          mem_raddr = rd_parent;
        end
      end
      S_LINK: begin
        // hang the smaller root under the larger
        mem_we    = 1'b1;
        mem_waddr = small_root;
        mem_wdata = {small_size, big_root};
        state_nxt = S_GROW;
      end
      S_GROW: begin
        mem_we    = 1'b1;
        mem_waddr = big_root;
        mem_wdata = {SZ_W'(sa_r + sb_r), big_root};
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_same_nxt  = same_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    out_same_r <= out_same_nxt;
    cmd_r      <= cmd_nxt;
    same_r     <= same_nxt;
    b_r        <= b_nxt;
    cur_r      <= cur_nxt;
    ra_r       <= ra_nxt;
    sa_r       <= sa_nxt;
    sb_r       <= sb_nxt;
  end

endmodule

// ----- src/wuf_checker.sv -----
`include "assert_macros.svh"

module wuf_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_same_set
);

  // Coming out of reset the clearing pass holds off input
  `WUF_ASSERT_ALWAYS(a_rst_blocks_in, !rst_n |=> !in_ready, "input ready right after reset")

  // One item at a time: ready drops after every accepted item
  `WUF_ASSERT(a_one_at_a_time, in_valid && in_ready |=> !in_ready, "second item taken back to back")

  // A stalled result stays offered
  `WUF_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result withdrawn while stalled")

  // A stalled result keeps its value
  `WUF_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_same_set), "result changed while stalled")

endmodule

bind weighted_union_find wuf_checker u_wuf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_same_set (out_ch.same_set)
);
